### hdl/wavhp_pkg.sv
// ----------------------------------------------------------------------------
// wavhp_pkg - WAV header parser shared types
// Beat and result payloads, status and walk codes, chunk tags.
// ----------------------------------------------------------------------------
`default_nettype none

package wavhp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] MIN_LENGTH = 32'd44;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SHORT   = 2'd1,
		ST_BAD_TAG = 2'd2,
		ST_NO_DATA = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		WALK_PENDING = 2'd0,
		WALK_FOUND   = 2'd1,
		WALK_NONE    = 2'd2
	} walk_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [31:0] file_length;
		logic        last_byte;
	} wavhp_beat_t;

	typedef struct packed {
		logic [15:0] fmt_code;
		logic [15:0] channel_count;
		logic [31:0] samples_per_sec;
		logic [31:0] bytes_per_sec;
		logic [15:0] frame_bytes;
		logic [15:0] sample_bits;
	} wavhp_fmt_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] fmt_code;
		logic [15:0] channel_count;
		logic [31:0] samples_per_sec;
		logic [31:0] bytes_per_sec;
		logic [15:0] frame_bytes;
		logic [15:0] sample_bits;
		logic [31:0] data_offset;
		logic [31:0] data_size;
	} wavhp_result_t;

	function automatic wavhp_result_t plain_result(input status_t st);
		wavhp_result_t r;
		r        = '0;
		r.status = st;
		return r;
	endfunction

	function automatic wavhp_result_t final_result(input wavhp_fmt_t fmt, input walk_t walk,
		input logic [31:0] start, input logic [31:0] size);
		wavhp_result_t r;
		logic          found;
		found             = (walk == WALK_FOUND);
		r.status          = (found && size != 32'd0) ? ST_OK : ST_NO_DATA;
		r.fmt_code        = fmt.fmt_code;
		r.channel_count   = fmt.channel_count;
		r.samples_per_sec = fmt.samples_per_sec;
		r.bytes_per_sec   = fmt.bytes_per_sec;
		r.frame_bytes     = fmt.frame_bytes;
		r.sample_bits     = fmt.sample_bits;
		r.data_offset     = found ? start + 32'd8 : 32'd0;
		r.data_size       = found ? size : 32'd0;
		return r;
	endfunction

endpackage

`default_nettype wire

### hdl/wav_header_parser_core.sv
// ----------------------------------------------------------------------------
// wav_header_parser_core - streaming RIFF/WAVE header parser
// Input register, parse step and result register.
// ----------------------------------------------------------------------------
// Usage:
//   wav carries one file byte per beat in file order, with the file length
//   (sampled on the first beat) and a last-byte flag that closes the file.
//   hdr carries one result per file: status, the six fmt fields, and the
//   data chunk offset and size.
//   A beat is parsed while it sits in the input register; when the parse step
//   takes it, its result goes to the output register and on to hdr. One byte
//   per cycle is taken for as long as the output register is empty or being
//   drained; the parse step keeps all its state in flip-flops and works each
//   byte with compares and adds of up to 34 bits.
//   Bytes after the result and up to the last-byte flag are taken and
//   dropped. While hdr is stalled with a result held, the input register
//   holds its beat and wav is stalled once that register is full.
//   Reset clears the parser to the start of a file and empties both
//   registers.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_header_parser_core
	import wavhp_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wav_valid,
	output logic               wav_stall,
	input  wire wavhp_beat_t   wav,
	output logic               hdr_valid,
	input  wire logic          hdr_stall,
	output wavhp_result_t      hdr
);

	logic          valid_s1;
	wavhp_beat_t   beat_s1;
	logic          go;
	logic          emit;
	wavhp_result_t res;

	assign go        = valid_s1 && (!hdr_valid || !hdr_stall);
	assign wav_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!wav_stall) begin
			valid_s1 <= wav_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!wav_stall && wav_valid) begin
			beat_s1 <= wav;
		end
	end

	wavhp_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.beat   (beat_s1),
		.emit   (emit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_valid <= 1'b0;
		end else if (go && emit) begin
			hdr_valid <= 1'b1;
		end else if (!hdr_stall) begin
			hdr_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			hdr <= res;
		end
	end

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		wav_stall |-> valid_s1 && hdr_valid && hdr_stall)
		else $error("input stalled with room to move");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && hdr_stall |-> !go)
		else $error("held result overwritten");

	a_beat_parsed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !hdr_valid |-> go)
		else $error("beat not parsed with output free");

endmodule

`default_nettype wire

### hdl/wavhp_step.sv
// ----------------------------------------------------------------------------
// wavhp_step - per-byte parse step
// Holds the parser state and works one registered beat per cycle, while go
// is high, into an optional result.
// ----------------------------------------------------------------------------
`default_nettype none

module wavhp_step
	import wavhp_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire wavhp_beat_t   beat,
	output logic               emit,
	output wavhp_result_t      res
);

	logic [31:0] pos_q, pos_n;
	logic [31:0] len_q, len_n;
	logic [31:0] shift_q, shift_n;
	logic [31:0] start_q, start_n;
	logic [31:0] tag_q, tag_n;
	logic [31:0] size_q, size_n;
	wavhp_fmt_t  fmt_q, fmt_n;
	logic        given_q, given_n;
	logic        walk_on_q, walk_on_n;
	walk_t       walk_q, walk_n;

	logic [31:0] w;
	logic [32:0] first_start;
	logic [32:0] pos33;
	logic [32:0] start33;
	logic [33:0] next_start;

	always_comb begin
		pos_n     = pos_q;
		len_n     = len_q;
		shift_n   = shift_q;
		start_n   = start_q;
		tag_n     = tag_q;
		size_n    = size_q;
		fmt_n     = fmt_q;
		given_n   = given_q;
		walk_on_n = walk_on_q;
		walk_n    = walk_q;
		emit      = 1'b0;
		res       = '0;

		w           = {beat.data_byte, shift_q[31:8]};
		first_start = 33'd20 + {1'b0, w};
		pos33       = {1'b0, pos_q};
		start33     = {1'b0, start_q};
		next_start  = {2'b00, start_q} + 34'd8 + {2'b00, w};

		if (!given_q && pos_q == 32'd0) begin
			len_n = beat.file_length;
			if (beat.file_length <= MIN_LENGTH) begin
				emit    = 1'b1;
				res     = plain_result(ST_SHORT);
				given_n = 1'b1;
			end
		end

		if (!given_n) begin
			shift_n = w;
			case (pos_q)
				32'd3: begin
					if (w != TAG_RIFF) begin
						emit    = 1'b1;
						res     = plain_result(ST_BAD_TAG);
						given_n = 1'b1;
					end
				end
				32'd11: begin
					if (w != TAG_WAVE) begin
						emit    = 1'b1;
						res     = plain_result(ST_BAD_TAG);
						given_n = 1'b1;
					end
				end
				32'd15: begin
					if (w != TAG_FMT) begin
						emit    = 1'b1;
						res     = plain_result(ST_BAD_TAG);
						given_n = 1'b1;
					end
				end
				32'd19: begin
					if (first_start <= {1'b0, len_q}) begin
						start_n   = first_start[31:0];
						walk_on_n = 1'b1;
					end else begin
						walk_n = WALK_NONE;
					end
				end
				32'd21: fmt_n.fmt_code        = w[31:16];
				32'd23: fmt_n.channel_count   = w[31:16];
				32'd27: fmt_n.samples_per_sec = w;
				32'd31: fmt_n.bytes_per_sec   = w;
				32'd33: fmt_n.frame_bytes     = w[31:16];
				32'd35: fmt_n.sample_bits     = w[31:16];
				default: ;
			endcase

			// the walk cannot match on the beat that starts it, so old state serves
			if (!given_n && walk_on_q && walk_q == WALK_PENDING) begin
				if (pos33 == start33 + 33'd3) begin
					tag_n = w;
				end else if (pos33 == start33 + 33'd7) begin
					if (tag_q == TAG_DATA) begin
						walk_n = WALK_FOUND;
						size_n = w;
					end else if (next_start <= {2'b00, len_q}) begin
						start_n = next_start[31:0];
					end else begin
						walk_n = WALK_NONE;
					end
				end
			end

			if (!given_n && walk_n != WALK_PENDING && pos_q >= 32'd35) begin
				emit    = 1'b1;
				res     = final_result(fmt_n, walk_n, start_n, size_n);
				given_n = 1'b1;
			end
		end

		if (beat.last_byte) begin
			if (!given_n) begin
				emit = 1'b1;
				if (pos_q < 32'd15) begin
					res = plain_result(ST_BAD_TAG);
				end else begin
					res = final_result(fmt_n, walk_n, start_n, size_n);
				end
			end
			pos_n     = '0;
			len_n     = '0;
			shift_n   = '0;
			start_n   = '0;
			tag_n     = '0;
			size_n    = '0;
			fmt_n     = '0;
			given_n   = 1'b0;
			walk_on_n = 1'b0;
			walk_n    = WALK_PENDING;
		end else if (pos_q != '1) begin
			pos_n = pos_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			len_q     <= '0;
			shift_q   <= '0;
			start_q   <= '0;
			tag_q     <= '0;
			size_q    <= '0;
			fmt_q     <= '0;
			given_q   <= 1'b0;
			walk_on_q <= 1'b0;
			walk_q    <= WALK_PENDING;
		end else if (go) begin
			pos_q     <= pos_n;
			len_q     <= len_n;
			shift_q   <= shift_n;
			start_q   <= start_n;
			tag_q     <= tag_n;
			size_q    <= size_n;
			fmt_q     <= fmt_n;
			given_q   <= given_n;
			walk_on_q <= walk_on_n;
			walk_q    <= walk_n;
		end
	end

	// one result per file
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		go && given_q |-> !emit)
		else $error("second result in one file");

	a_short_file: assert property (@(posedge clk) disable iff (!arst_n)
		go && pos_q == 32'd0 && beat.file_length <= MIN_LENGTH
		|-> emit && res.status == ST_SHORT)
		else $error("short file not rejected on first beat");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && beat.last_byte |=> pos_q == 32'd0 && !given_q && walk_q == WALK_PENDING)
		else $error("parser not cleared after last beat");

	a_last_reports: assert property (@(posedge clk) disable iff (!arst_n)
		go && beat.last_byte && !given_q |-> emit)
		else $error("file ended without a result");

endmodule

`default_nettype wire
